FILE: hw/rtl/playfair_digraph_cipher_top_defines.svh
// Assertion macros for the Playfair digraph cipher block.
// Used by the top level only; no other dependencies.
`ifndef PLAYFAIR_DIGRAPH_CIPHER_TOP_DEFINES_SVH
`define PLAYFAIR_DIGRAPH_CIPHER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while in reset.
`define PLF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("plf assertion failed");
// Next-cycle implication, disabled while in reset.
`define PLF_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("plf assertion failed");
`else
`define PLF_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define PLF_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

FILE: hw/rtl/plf_pkg.sv
// Package for the Playfair digraph cipher: letter codes, register indexes,
// square and job types, and wrap helpers. No dependencies.
`timescale 1ns / 1ps

package plf_pkg;

    typedef logic [4:0] t_letter;
    typedef logic [2:0] t_pos;
    // Row-major square: sq[row][col], cell 0 at bits 4:0.
    typedef logic [4:0][4:0][4:0] t_square;

    localparam t_letter LETTER_I = 5'd8;
    localparam t_letter LETTER_J = 5'd9;
    localparam t_letter LETTER_X = 5'd23;

    localparam logic [7:0] ASCII_UP_A = 8'h41;
    localparam logic [7:0] ASCII_UP_Z = 8'h5A;
    localparam logic [7:0] ASCII_LO_A = 8'h61;
    localparam logic [7:0] ASCII_LO_Z = 8'h7A;
    localparam logic [7:0] ASCII_CASE = 8'h20;

    localparam int CFG_DATA_W = 50;
    localparam logic [1:0] CFG_DIRECTION  = 2'd0;
    localparam logic [1:0] CFG_ROWS_LOW   = 2'd1;
    localparam logic [1:0] CFG_ROWS_MID   = 2'd2;
    localparam logic [1:0] CFG_ROW_HIGH   = 2'd3;

    localparam logic [49:0] RST_ROWS_LOW = 50'd360886946596896;
    localparam logic [49:0] RST_ROWS_MID = 50'd725215444678027;
    localparam logic [24:0] RST_ROW_HIGH = 25'd27025109;

    // One pair of letters waiting for the cipher, or a bare end marker.
    typedef struct packed {
        t_letter first;
        t_letter second;
        logic    done;
        logic    marker;
    } t_job;

    typedef struct packed {
        t_letter out_a;
        t_letter out_b;
    } t_pair_out;

    localparam t_pos POS_LAST = 3'd4;

    function automatic t_pos pos_inc(input t_pos p);
        t_pos res;
        res = (p == POS_LAST) ? 3'd0 : 3'(p + 3'd1);
        return res;
    endfunction

    function automatic t_pos pos_dec(input t_pos p);
        t_pos res;
        res = (p == 3'd0) ? POS_LAST : 3'(p - 3'd1);
        return res;
    endfunction

endpackage

FILE: hw/rtl/plf_cipher.sv
// Playfair pair transform: locates both letters in the square by parallel
// compare and applies the row, column or rectangle rule. Uses plf_pkg.
`timescale 1ns / 1ps

module plf_cipher
    import plf_pkg::*;
(
    input  t_square   i_square,
    input  logic      i_decrypt,
    input  t_job      i_job,
    output t_pair_out o_pair
);

    t_pos row_a, col_a, row_b, col_b;
    t_pos orow_a, ocol_a, orow_b, ocol_b;

    // Scan downward so the lowest matching cell is the last one written.
    always_comb begin
        row_a = 3'd0;
        col_a = 3'd0;
        row_b = 3'd0;
        col_b = 3'd0;
        for (int r = 4; r >= 0; r--) begin
            for (int c = 4; c >= 0; c--) begin
                if (i_square[r][c] == i_job.first) begin
                    row_a = 3'(r);
                    col_a = 3'(c);
                end
                if (i_square[r][c] == i_job.second) begin
                    row_b = 3'(r);
                    col_b = 3'(c);
                end
            end
        end
    end

    always_comb begin
        priority if (row_a == row_b) begin
            orow_a = row_a;
            orow_b = row_b;
            ocol_a = i_decrypt ? pos_dec(col_a) : pos_inc(col_a);
            ocol_b = i_decrypt ? pos_dec(col_b) : pos_inc(col_b);
        end else if (col_a == col_b) begin
            orow_a = i_decrypt ? pos_dec(row_a) : pos_inc(row_a);
            orow_b = i_decrypt ? pos_dec(row_b) : pos_inc(row_b);
            ocol_a = col_a;
            ocol_b = col_b;
        end else begin
            // Rectangle: swap columns, keep rows.
            orow_a = row_a;
            orow_b = row_b;
            ocol_a = col_b;
            ocol_b = col_a;
        end
    end

    assign o_pair = {i_square[orow_a][ocol_a], i_square[orow_b][ocol_b]};

endmodule

FILE: hw/rtl/playfair_digraph_cipher_top.sv
// Playfair digraph cipher top level: text conditioning, pair holding, job
// register, cipher and two-entry result buffer. Uses plf_pkg, plf_cipher.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+---------------------------------
//  input   | in        | i_in_valid / o_in_ready   | i_char_in, i_text_end
//  result  | out       | o_out_valid / i_out_ready | o_char_out, o_has_char,
//          |           |                           | o_message_done
//  config  | in        | i_cfg_we (no wait)        | i_cfg_addr, i_cfg_data
//
// One byte can be taken every cycle while the job register is empty or can drain.
// A completed pair gives two results through the single result port. A byte's
// first result passes through the job register, then the result buffer.
// Synchronous active-low reset restores the config defaults and clears the valid flags.
// A stalled result holds the buffer; the job register then fills and ready drops.
`timescale 1ns / 1ps
`include "playfair_digraph_cipher_top_defines.svh"

module playfair_digraph_cipher_top
    import plf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [7:0]            i_char_in,
    input  logic                  i_text_end,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [7:0]            o_char_out,
    output logic                  o_has_char,
    output logic                  o_message_done
);

    logic        r_direction;
    logic [49:0] r_rows_low;
    logic [49:0] r_rows_mid;
    logic [24:0] r_row_high;

    t_letter     r_held_letter;
    logic        r_held_valid;
    t_letter     n_held_letter;
    logic        n_held_valid;

    logic        r_job_v;
    t_job        r_job;
    t_job        n_job;
    logic        n_job_v;

    logic [1:0]  r_ob_cnt;
    logic [7:0]  r_ob0_char;
    logic        r_ob0_has;
    logic        r_ob0_done;
    logic [7:0]  r_ob1_char;
    logic        r_ob1_done;

    logic        in_fire;
    logic        out_fire;
    logic        load_ok;
    logic        job_load;
    logic [7:0]  ch_up;
    logic        is_letter;
    t_letter     letter;
    t_square     square;
    t_pair_out   pair;

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_direction <= 1'b0;
            r_rows_low  <= RST_ROWS_LOW;
            r_rows_mid  <= RST_ROWS_MID;
            r_row_high  <= RST_ROW_HIGH;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_DIRECTION: r_direction <= i_cfg_data[0];
                CFG_ROWS_LOW:  r_rows_low  <= i_cfg_data[49:0];
                CFG_ROWS_MID:  r_rows_mid  <= i_cfg_data[49:0];
                CFG_ROW_HIGH:  r_row_high  <= i_cfg_data[24:0];
                default:       r_direction <= r_direction;
            endcase
        end
    end

    assign square = t_square'({r_row_high, r_rows_mid, r_rows_low});

    // ---------------- handshakes ----------------
    assign o_out_valid = (r_ob_cnt != 2'd0);
    assign out_fire    = o_out_valid && i_out_ready;
    assign load_ok     = (r_ob_cnt == 2'd0) || ((r_ob_cnt == 2'd1) && out_fire);
    assign job_load    = r_job_v && load_ok;
    assign o_in_ready  = !r_job_v || load_ok;
    assign in_fire     = i_in_valid && o_in_ready;

    // ---------------- conditioning ----------------
    always_comb begin
        if ((i_char_in >= ASCII_LO_A) && (i_char_in <= ASCII_LO_Z)) begin
            ch_up = i_char_in - ASCII_CASE;
        end else begin
            ch_up = i_char_in;
        end
        is_letter = (ch_up >= ASCII_UP_A) && (ch_up <= ASCII_UP_Z);
        letter    = 5'(ch_up - ASCII_UP_A);
        if (letter == LETTER_J) begin
            letter = LETTER_I;
        end
    end

    // Pair up letters; at end of text pad with X or emit the bare marker.
    always_comb begin
        n_held_letter = r_held_letter;
        n_held_valid  = r_held_valid;
        n_job_v       = 1'b0;
        n_job         = '{first: r_held_letter, second: letter, done: i_text_end,
                          marker: 1'b0};
        if (i_text_end) begin
            n_job_v       = 1'b1;
            n_held_letter = 5'd0;
            n_held_valid  = 1'b0;
            priority if (is_letter && r_held_valid) begin
                n_job.second = letter;
            end else if (is_letter) begin
                n_job.first  = letter;
                n_job.second = LETTER_X;
            end else if (r_held_valid) begin
                n_job.second = LETTER_X;
            end else begin
                n_job.marker = 1'b1;
            end
        end else if (is_letter) begin
            if (r_held_valid) begin
                n_job_v       = 1'b1;
                n_held_letter = 5'd0;
                n_held_valid  = 1'b0;
            end else begin
                n_held_letter = letter;
                n_held_valid  = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_letter <= 5'd0;
            r_held_valid  <= 1'b0;
            r_job_v       <= 1'b0;
        end else begin
            if (in_fire) begin
                r_held_letter <= n_held_letter;
                r_held_valid  <= n_held_valid;
            end
            // Drain the job when the buffer takes it; refill on a producing beat.
            if (in_fire && n_job_v) begin
                r_job_v <= 1'b1;
            end else if (job_load) begin
                r_job_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire && n_job_v) begin
            r_job <= n_job;
        end
    end

    // ---------------- cipher ----------------
    plf_cipher u_cipher (
        .i_square  (square),
        .i_decrypt (r_direction),
        .i_job     (r_job),
        .o_pair    (pair)
    );

    // ---------------- result buffer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ob_cnt <= 2'd0;
        end else if (job_load) begin
            r_ob_cnt <= r_job.marker ? 2'd1 : 2'd2;
        end else if (out_fire) begin
            r_ob_cnt <= 2'(r_ob_cnt - 2'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (job_load) begin
            if (r_job.marker) begin
                r_ob0_char <= 8'd0;
                r_ob0_has  <= 1'b0;
                r_ob0_done <= 1'b1;
            end else begin
                r_ob0_char <= 8'(ASCII_UP_A + {3'd0, pair.out_a});
                r_ob0_has  <= 1'b1;
                r_ob0_done <= 1'b0;
            end
            r_ob1_char <= 8'(ASCII_UP_A + {3'd0, pair.out_b});
            r_ob1_done <= r_job.done;
        end else if (out_fire && (r_ob_cnt == 2'd2)) begin
            // Advance the second letter of the pair to the head.
            r_ob0_char <= r_ob1_char;
            r_ob0_has  <= 1'b1;
            r_ob0_done <= r_ob1_done;
        end
    end

    assign o_char_out     = r_ob0_char;
    assign o_has_char     = r_ob0_has;
    assign o_message_done = r_ob0_done;

    // ---------------- assertions ----------------
    `PLF_ASSERT_NXT(a_two_drain, i_clk, i_rst_n, out_fire && (r_ob_cnt == 2'd2), r_ob_cnt == 2'd1)
    `PLF_ASSERT_IMP(a_marker_done, i_clk, i_rst_n, o_out_valid && !o_has_char, o_message_done)
    `PLF_ASSERT_NXT(a_end_job, i_clk, i_rst_n, in_fire && i_text_end, r_job_v && !r_held_valid)
    `PLF_ASSERT_NXT(a_load_fill, i_clk, i_rst_n, job_load, r_ob_cnt != 2'd0)

endmodule

FILE: bench/tb_top.sv
// Self-checking bench for playfair_digraph_cipher_top: random and directed text, square setups.
// Expected letters come from a predictor kept in step with every accepted input beat.
// Depends on plf_pkg and the cipher RTL.
`timescale 1ns / 1ps

module tb_top;
    import plf_pkg::*;

    typedef struct {
        logic [7:0] ch;
        logic       fin;
    } text_beat_t;

    typedef struct {
        logic [7:0] ch;
        logic       has;
        logic       done;
    } cipher_beat_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [1:0]            cfg_addr  = CFG_DIRECTION;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_valid  = 1'b0;
    logic [7:0]            in_char   = 8'h00;
    logic                  in_end    = 1'b0;
    logic                  out_ready = 1'b0;
    logic                  in_ready;
    logic                  out_valid;
    logic [7:0]            out_char;
    logic                  out_has;
    logic                  out_done;

    text_beat_t   pending_bytes[$];
    cipher_beat_t expected_letters[$];
    int           send_idle_pct  = 0;
    int           recv_idle_pct  = 0;
    int           mismatch_count = 0;
    int           queued_total   = 0;

    // Predictor copy of the block's registers and pair state.
    logic         dir_decrypt = 1'b0;
    logic [124:0] square_bits = {RST_ROW_HIGH, RST_ROWS_MID, RST_ROWS_LOW};
    t_letter      held_first  = '0;
    logic         held_ok     = 1'b0;

    playfair_digraph_cipher_top i_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_addr     (cfg_addr),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_char_in      (in_char),
        .i_text_end     (in_end),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_char_out     (out_char),
        .o_has_char     (out_has),
        .o_message_done (out_done)
    );

    always #2 clk = ~clk;

    function automatic t_letter cell_at(int k);
        return square_bits[5*k +: 5];
    endfunction

    // Lowest matching cell wins; a letter not in the square sits at cell 0.
    function automatic int cell_of(t_letter l);
        for (int k = 0; k < 25; k++) begin
            if (cell_at(k) == l) return k;
        end
        return 0;
    endfunction

    function automatic void push_pair(t_letter a, t_letter b, logic done);
        int pa, pb, ra, ca, rb, cb, sh, oa, ob;
        cipher_beat_t r;
        pa = cell_of(a);
        pb = cell_of(b);
        ra = pa / 5;
        ca = pa % 5;
        rb = pb / 5;
        cb = pb % 5;
        sh = dir_decrypt ? 4 : 1;
        if (ra == rb) begin
            oa = ra * 5 + (ca + sh) % 5;
            ob = rb * 5 + (cb + sh) % 5;
        end else if (ca == cb) begin
            oa = ((ra + sh) % 5) * 5 + ca;
            ob = ((rb + sh) % 5) * 5 + cb;
        end else begin
            oa = ra * 5 + cb;
            ob = rb * 5 + ca;
        end
        r.ch   = ASCII_UP_A + 8'(cell_at(oa));
        r.has  = 1'b1;
        r.done = 1'b0;
        expected_letters.push_back(r);
        r.ch   = ASCII_UP_A + 8'(cell_at(ob));
        r.done = done;
        expected_letters.push_back(r);
    endfunction

    function automatic void predict_cipher(logic [7:0] ch, logic fin);
        logic [7:0]   up;
        logic         is_letter;
        t_letter      l;
        logic         emitted;
        cipher_beat_t marker;
        up = (ch >= ASCII_LO_A && ch <= ASCII_LO_Z) ? ch - ASCII_CASE : ch;
        is_letter = (up >= ASCII_UP_A && up <= ASCII_UP_Z);
        l = 5'(up - ASCII_UP_A);
        if (l == LETTER_J) l = LETTER_I;
        emitted = 1'b0;
        if (is_letter) begin
            if (held_ok) begin
                push_pair(held_first, l, fin);
                held_ok    = 1'b0;
                held_first = '0;
                emitted    = 1'b1;
            end else begin
                held_first = l;
                held_ok    = 1'b1;
            end
        end
        if (fin) begin
            if (held_ok) begin
                // odd letter at end: pad with X
                push_pair(held_first, LETTER_X, 1'b1);
                held_ok    = 1'b0;
                held_first = '0;
            end else if (!emitted) begin
                marker.ch   = 8'h00;
                marker.has  = 1'b0;
                marker.done = 1'b1;
                expected_letters.push_back(marker);
            end
        end
    endfunction

    task automatic report_mismatch(string what, logic [7:0] want, logic [7:0] got);
        mismatch_count++;
        if (mismatch_count <= 100)
            $display("%0t mismatch on %s: expected %02h, got %02h", $time, what, want, got);
    endtask

    always @(posedge clk) begin : byte_driver
        text_beat_t nxt;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) predict_cipher(in_char, in_end);
            if (!in_valid || in_ready) begin
                if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = pending_bytes.pop_front();
                    in_valid <= 1'b1;
                    in_char  <= nxt.ch;
                    in_end   <= nxt.fin;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk) begin : result_monitor
        cipher_beat_t want;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (expected_letters.size() == 0) begin
                    report_mismatch("unexpected beat", 8'h00, out_char);
                end else begin
                    want = expected_letters.pop_front();
                    if (out_char !== want.ch) report_mismatch("char_out", want.ch, out_char);
                    if (out_has !== want.has)
                        report_mismatch("has_char", {7'd0, want.has}, {7'd0, out_has});
                    if (out_done !== want.done)
                        report_mismatch("message_done", {7'd0, want.done}, {7'd0, out_done});
                end
            end
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic void queue_byte(logic [7:0] ch, logic fin);
        text_beat_t b;
        b.ch  = ch;
        b.fin = fin;
        pending_bytes.push_back(b);
        queued_total++;
    endfunction

    // Letters come mostly from the current square, biased toward shared rows and columns.
    function automatic void queue_message(int len);
        int         k, prev_k, r;
        t_letter    l;
        logic [7:0] ch;
        prev_k = $urandom_range(24);
        for (int i = 0; i < len; i++) begin
            r = $urandom_range(99);
            if (r < 8) begin
                ch = 8'($urandom_range(255));
            end else begin
                k = $urandom_range(24);
                if (r < 30) k = (prev_k / 5) * 5 + k % 5;
                else if (r < 50) k = (k / 5) * 5 + prev_k % 5;
                prev_k = k;
                l = cell_at(k);
                if (l > 5'd25 || $urandom_range(9) == 0) l = 5'($urandom_range(25));
                if (l == LETTER_I && $urandom_range(1) == 1) l = LETTER_J;
                ch = ASCII_UP_A + 8'(l);
                if ($urandom_range(1) == 1) ch = ch + ASCII_CASE;
            end
            queue_byte(ch, i == len - 1);
        end
    endfunction

    function automatic void queue_random(int count);
        int stop_at;
        stop_at = queued_total + count;
        while (queued_total < stop_at) begin
            if ($urandom_range(9) == 0) begin
                // noise and broken messages
                repeat ($urandom_range(1, 4))
                    queue_byte(8'($urandom_range(255)), $urandom_range(3) == 0);
            end else begin
                queue_message($urandom_range(1, 14));
            end
        end
    endfunction

    function automatic logic [124:0] shuffled_square();
        t_letter      pool[25];
        t_letter      t;
        int           j;
        logic [124:0] sq;
        j = 0;
        for (int l = 0; l < 26; l++) begin
            if (5'(l) != LETTER_J) begin
                pool[j] = 5'(l);
                j++;
            end
        end
        for (int i = 24; i > 0; i--) begin
            j = $urandom_range(i);
            t = pool[i];
            pool[i] = pool[j];
            pool[j] = t;
        end
        for (int i = 0; i < 25; i++) sq[5*i +: 5] = pool[i];
        return sq;
    endfunction

    task automatic wait_drained();
        while (pending_bytes.size() != 0 || in_valid || expected_letters.size() != 0)
            @(posedge clk);
        // a held letter gives no result; let the pipeline settle
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we   <= 1'b0;
        case (idx)
            CFG_DIRECTION: dir_decrypt            = val[0];
            CFG_ROWS_LOW:  square_bits[49:0]      = val;
            CFG_ROWS_MID:  square_bits[99:50]     = val;
            CFG_ROW_HIGH:  square_bits[124:100]   = val[24:0];
            default:       ;
        endcase
    endtask

    task automatic load_setup(logic dir, logic [124:0] sq);
        write_reg(CFG_DIRECTION, {49'($urandom()) ^ {17'd0, 32'($urandom())}, dir});
        write_reg(CFG_ROWS_LOW, sq[49:0]);
        write_reg(CFG_ROWS_MID, sq[99:50]);
        write_reg(CFG_ROW_HIGH, {25'($urandom()), sq[124:100]});
    endtask

    initial begin : stimulus
        logic [124:0] sq;
        logic         dir;
        send_idle_pct = 29;
        recv_idle_pct = 85;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: byte extremes, letter boundaries, J folding, each end case
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'h40, 1'b0);
        queue_byte(8'h5B, 1'b0);
        queue_byte(8'h60, 1'b0);
        queue_byte(8'h7B, 1'b0);
        queue_byte("A", 1'b0);
        queue_byte("z", 1'b0);
        queue_byte("a", 1'b0);
        queue_byte("Z", 1'b0);
        queue_byte("J", 1'b0);
        queue_byte("j", 1'b0);
        queue_byte("!", 1'b1);
        queue_byte("Q", 1'b0);
        queue_byte("K", 1'b1);
        queue_byte("M", 1'b1);
        queue_byte("B", 1'b0);
        queue_byte("1", 1'b1);
        queue_byte("C", 1'b0);
        queue_byte("D", 1'b0);
        queue_byte(8'h80, 1'b1);
        // hold the sender until every result is back
        wait_drained();
        queue_random(160);

        for (int ph = 1; ph <= 7; ph++) begin
            wait_drained();
            if (ph >= 6) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end else if (ph >= 3) begin
                send_idle_pct = 85;
                recv_idle_pct = 29;
            end
            case (ph)
                1: begin dir = 1'b0; sq = shuffled_square(); end
                2: begin dir = 1'b1; sq = shuffled_square(); end
                3: begin dir = 1'b1; sq = '0; end
                4: begin dir = 1'b0; sq = '1; end
                5: begin
                    dir = 1'b0;
                    sq  = 125'({$urandom(), $urandom(), $urandom(), $urandom()});
                end
                6: begin dir = 1'b1; sq = shuffled_square(); end
                default: begin dir = 1'b0; sq = shuffled_square(); end
            endcase
            load_setup(dir, sq);
            queue_random(160);
        end

        wait_drained();
        repeat (16) @(posedge clk);
        if (expected_letters.size() != 0)
            report_mismatch("results never delivered", 8'h00, 8'(expected_letters.size()));
        if (mismatch_count == 0) begin
            $display("[playfair_digraph_cipher_top] OK");
        end else begin
            $display("[playfair_digraph_cipher_top] ERROR");
        end
        $finish;
    end

    initial begin : watchdog
        #3_000_000;
        $display("[playfair_digraph_cipher_top] ERROR");
        $finish;
    end

endmodule
